// File: src/abhv_pkg.sv
// Shared types and constants for the array blob header validator.
`default_nettype none

package abhv_pkg;

    // Default build values for the top-level parameters
    localparam int DEF_VALUE_BYTES = 8;
    localparam int DEF_COUNT_WIDTH = 64;

    // Fixed field widths
    localparam int WORD_W   = 32;
    localparam int LEN_W    = 32;
    localparam int DIM_W    = 30;
    localparam int STATUS_W = 3;

    // Bytes taken by the count word and by each size word
    localparam logic [LEN_W-1:0] HDR_BYTES = 32'd4;

    // Verdict codes
    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 3'd0,
        ST_SHORT = 3'd1,
        ST_DIMS  = 3'd2,
        ST_NEG   = 3'd3,
        ST_OVF   = 3'd4,
        ST_LEN   = 3'd5
    } t_status;

    // Event passed from the header walker to the verdict stage
    typedef struct packed {
        logic             fin_chk;   // all sizes seen: run the length check
        t_status          status;    // verdict when fin_chk is low
        logic [DIM_W-1:0] dims;      // dimension count of the blob
        logic [LEN_W-1:0] blob_len;  // total blob length in bytes
    } t_evt;

endpackage

`default_nettype wire

// File: src/abhv_if.sv
// Valid/ready channel interfaces for header words in and verdicts out.
`default_nettype none

interface abhv_in_if;
    logic                            valid;
    logic                            ready;
    logic                            first;
    logic signed [abhv_pkg::WORD_W-1:0] word;
    logic [abhv_pkg::LEN_W-1:0]      payload_bytes;

    modport source (output valid, output first, output word, output payload_bytes,
                    input ready);
    modport sink   (input valid, input first, input word, input payload_bytes,
                    output ready);
endinterface

interface abhv_out_if;
    logic                          valid;
    logic                          ready;
    logic [abhv_pkg::STATUS_W-1:0] status;
    logic [abhv_pkg::DIM_W-1:0]    dimension_count;
    logic [abhv_pkg::DIM_W-1:0]    value_count;
    logic [abhv_pkg::LEN_W-1:0]    data_offset;

    modport source (output valid, output status, output dimension_count,
                    output value_count, output data_offset, input ready);
    modport sink   (input valid, input status, input dimension_count,
                    input value_count, input data_offset, output ready);
endinterface

`default_nettype wire

// File: src/abhv_step.sv
// Header walker: blob state, size-product multiply with overflow detect.
`default_nettype none

module abhv_step #(
    parameter int COUNT_WIDTH = abhv_pkg::DEF_COUNT_WIDTH
) (
    input  wire                             i_clk,
    input  wire                             i_rst_n,
    // registered header word
    input  wire                             i_valid,
    output logic                            o_ready,
    input  wire                             i_first,
    input  wire  [abhv_pkg::WORD_W-1:0]     i_word,
    input  wire  [abhv_pkg::LEN_W-1:0]      i_payload_bytes,
    // event toward the verdict stage
    output logic                            o_ev_valid,
    input  wire                             i_ev_ready,
    output abhv_pkg::t_evt                  o_ev,
    output logic [COUNT_WIDTH-1:0]          o_ev_product
);

    localparam int RAW_W  = abhv_pkg::WORD_W - 1;
    localparam int HALF_W = 32;
    localparam int PP_W   = HALF_W + RAW_W;
    localparam int FULL_W = HALF_W + PP_W;

    // Blob state
    logic                             r_busy,       n_busy;
    logic [abhv_pkg::DIM_W-1:0]       r_dims_total, n_dims_total;
    logic [abhv_pkg::DIM_W-1:0]       r_dims_left,  n_dims_left;
    logic [abhv_pkg::LEN_W-1:0]       r_blob_len,   n_blob_len;
    logic [COUNT_WIDTH-1:0]           r_product,    n_product;

    // Event register
    logic                             r_ev_valid;
    abhv_pkg::t_evt                   r_ev,         n_ev;
    logic [COUNT_WIDTH-1:0]           r_ev_product;
    logic                             ev_hit;

    logic                             accept;
    logic                             negative;
    logic [RAW_W-1:0]                 raw;
    logic [abhv_pkg::LEN_W-1:0]       dims_room;
    logic [abhv_pkg::DIM_W-1:0]       dims_dec;

    // Product split into two 32-bit halves
    logic [HALF_W-1:0]                prod_lo;
    logic [HALF_W-1:0]                prod_hi;
    logic [PP_W-1:0]                  pp_lo;
    logic [PP_W-1:0]                  pp_hi;
    logic [FULL_W-1:0]                prod_full;
    logic                             mul_ovf;

    assign o_ready  = !r_ev_valid || i_ev_ready;
    assign accept   = i_valid && o_ready;
    assign negative = i_word[abhv_pkg::WORD_W-1];
    assign raw      = i_word[RAW_W-1:0];

    // Largest count that still fits after the count word
    assign dims_room = (i_payload_bytes - abhv_pkg::HDR_BYTES) >> 2;
    assign dims_dec  = r_dims_left - abhv_pkg::DIM_W'(1);

    // Running product times this size, as two partial products
    assign prod_lo   = r_product[HALF_W-1:0];
    assign prod_hi   = HALF_W'(r_product >> HALF_W);
    assign pp_lo     = {{RAW_W{1'b0}}, prod_lo} * {{HALF_W{1'b0}}, raw};
    assign pp_hi     = {{RAW_W{1'b0}}, prod_hi} * {{HALF_W{1'b0}}, raw};
    assign prod_full = {pp_hi, {HALF_W{1'b0}}} + {{HALF_W{1'b0}}, pp_lo};
    assign mul_ovf   = (prod_full >> COUNT_WIDTH) != '0;

    // Next state and event for one header word
    always_comb begin
        n_busy       = r_busy;
        n_dims_total = r_dims_total;
        n_dims_left  = r_dims_left;
        n_blob_len   = r_blob_len;
        n_product    = r_product;
        ev_hit       = 1'b0;
        n_ev.fin_chk  = 1'b0;
        n_ev.status   = abhv_pkg::ST_OK;
        n_ev.dims     = r_dims_total;
        n_ev.blob_len = r_blob_len;

        if (i_first) begin
            n_busy = 1'b0;
            if (i_payload_bytes < abhv_pkg::HDR_BYTES) begin
                ev_hit      = 1'b1;
                n_ev.status = abhv_pkg::ST_SHORT;
            end else if (negative || raw == '0 ||
                         abhv_pkg::LEN_W'(raw) > dims_room) begin
                ev_hit      = 1'b1;
                n_ev.status = abhv_pkg::ST_DIMS;
            end else begin
                n_busy       = 1'b1;
                n_dims_total = raw[abhv_pkg::DIM_W-1:0];
                n_dims_left  = raw[abhv_pkg::DIM_W-1:0];
                n_blob_len   = i_payload_bytes;
                n_product    = COUNT_WIDTH'(1);
            end
        end else if (r_busy) begin
            if (negative) begin
                n_busy      = 1'b0;
                ev_hit      = 1'b1;
                n_ev.status = abhv_pkg::ST_NEG;
            end else if (mul_ovf) begin
                n_busy      = 1'b0;
                ev_hit      = 1'b1;
                n_ev.status = abhv_pkg::ST_OVF;
            end else begin
                // a zero size gives a zero product, which then stays zero
                n_product   = prod_full[COUNT_WIDTH-1:0];
                n_dims_left = dims_dec;
                if (dims_dec == '0) begin
                    n_busy       = 1'b0;
                    ev_hit       = 1'b1;
                    n_ev.fin_chk = 1'b1;
                end
            end
        end
    end

    // Blob state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy       <= 1'b0;
            r_dims_total <= '0;
            r_dims_left  <= '0;
            r_blob_len   <= '0;
            r_product    <= COUNT_WIDTH'(1);
        end else if (accept) begin
            r_busy       <= n_busy;
            r_dims_total <= n_dims_total;
            r_dims_left  <= n_dims_left;
            r_blob_len   <= n_blob_len;
            r_product    <= n_product;
        end
    end

    // Event valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ev_valid <= 1'b0;
        end else if (o_ready) begin
            r_ev_valid <= accept && ev_hit;
        end
    end

    // Event payload
    always_ff @(posedge i_clk) begin
        if (accept && ev_hit) begin
            r_ev         <= n_ev;
            r_ev_product <= n_product;
        end
    end

    assign o_ev_valid   = r_ev_valid;
    assign o_ev         = r_ev;
    assign o_ev_product = r_ev_product;

    // An open blob always has sizes still to come, no more than it announced
    a_dims_left_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> (r_dims_left != '0 && r_dims_left <= r_dims_total))
        else $error("dims_left out of range while busy");

    // An open blob's count fits its length
    a_dims_fit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> (abhv_pkg::LEN_W'(r_dims_total) <=
                    ((r_blob_len - abhv_pkg::HDR_BYTES) >> 2)))
        else $error("dimension count exceeds blob length");

    // Any transaction that yields a verdict closes the blob
    a_verdict_closes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && ev_hit) |=> !r_busy)
        else $error("blob still open after verdict");

endmodule

`default_nettype wire

// File: src/abhv_verdict.sv
// Verdict stage: element byte check and the result register.
`default_nettype none

module abhv_verdict #(
    parameter int VALUE_BYTES = abhv_pkg::DEF_VALUE_BYTES,
    parameter int COUNT_WIDTH = abhv_pkg::DEF_COUNT_WIDTH
) (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    // event from the header walker
    input  wire                              i_valid,
    output logic                             o_ready,
    input  wire  abhv_pkg::t_evt             i_ev,
    input  wire  [COUNT_WIDTH-1:0]           i_product,
    // result register
    output logic                             o_valid,
    input  wire                              i_ready,
    output abhv_pkg::t_status                o_status,
    output logic [abhv_pkg::DIM_W-1:0]       o_dims,
    output logic [abhv_pkg::DIM_W-1:0]       o_values,
    output logic [abhv_pkg::LEN_W-1:0]       o_offset
);

    localparam int VB_W = COUNT_WIDTH + 4;

    logic                             r_valid;
    abhv_pkg::t_status                r_status, n_status;
    logic [abhv_pkg::DIM_W-1:0]       r_dims,   n_dims;
    logic [abhv_pkg::DIM_W-1:0]       r_values, n_values;
    logic [abhv_pkg::LEN_W-1:0]       r_offset, n_offset;

    logic [abhv_pkg::LEN_W-1:0]       header;
    logic [abhv_pkg::LEN_W-1:0]       rest;
    logic [VB_W-1:0]                  vbytes;
    logic                             vb_ovf;
    logic                             len_ok;
    logic                             accept;

    assign o_ready = !r_valid || i_ready;
    assign accept  = i_valid && o_ready;

    // Header size, bytes left for values, and bytes the values need
    assign header = {i_ev.dims, 2'b00} + abhv_pkg::HDR_BYTES;
    assign rest   = i_ev.blob_len - header;
    assign vbytes = VB_W'(i_product) * VB_W'(VALUE_BYTES);
    assign vb_ovf = (vbytes >> COUNT_WIDTH) != '0;
    assign len_ok = vbytes == VB_W'(rest);

    // Final status and fields
    always_comb begin
        n_status = i_ev.status;
        n_dims   = '0;
        n_values = '0;
        n_offset = '0;
        if (i_ev.fin_chk) begin
            if (vb_ovf) begin
                n_status = abhv_pkg::ST_OVF;
            end else if (!len_ok) begin
                n_status = abhv_pkg::ST_LEN;
            end else begin
                n_status = abhv_pkg::ST_OK;
                n_dims   = i_ev.dims;
                n_values = i_product[abhv_pkg::DIM_W-1:0];
                n_offset = header;
            end
        end
    end

    // Result valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    // Result payload
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_status <= n_status;
            r_dims   <= n_dims;
            r_values <= n_values;
            r_offset <= n_offset;
        end
    end

    assign o_valid  = r_valid;
    assign o_status = r_status;
    assign o_dims   = r_dims;
    assign o_values = r_values;
    assign o_offset = r_offset;

    // Errors carry zero fields
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && r_status != abhv_pkg::ST_OK) |->
            (r_dims == '0 && r_values == '0 && r_offset == '0))
        else $error("error verdict with nonzero fields");

    // A good verdict points past the count word and one word per dimension
    a_ok_offset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && r_status == abhv_pkg::ST_OK) |->
            (r_offset == {r_dims, 2'b00} + abhv_pkg::HDR_BYTES && r_dims != '0))
        else $error("data offset does not match dimension count");

endmodule

`default_nettype wire

// File: src/array_blob_header_validator.sv
// Top level of the array blob header validator: input register and stage wiring.
//
// Usage:
//   i_in carries one header word per transaction. A transaction with first
//   set opens a blob: word is the dimension count and payload_bytes the
//   blob's total length. Each following transaction carries one dimension
//   size. o_out carries one verdict per blob (status, dimension_count,
//   value_count, data_offset); a bad count or length is reported on the
//   first word itself. Words after the verdict and before the next first
//   word are dropped, and a new first word abandons an open blob silently.
// Throughput: one word per cycle while no stage is stalled; the size multiply with its overflow
//   check sits between the input register and the blob state registers.
// Path: the word that decides a verdict passes through the input register, the
//   walker's event register and the result register, in that order.
// Reset: synchronous, active low; clears all valid flags and closes any
//   open blob. No memory, so no clearing pass.
// Stall: each stage holds when the next one is full; the input register
//   still takes a word while a verdict waits at o_out.
`default_nettype none

module array_blob_header_validator #(
    parameter int VALUE_BYTES = abhv_pkg::DEF_VALUE_BYTES,
    parameter int COUNT_WIDTH = abhv_pkg::DEF_COUNT_WIDTH
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    abhv_in_if.sink     i_in,
    abhv_out_if.source  o_out
);

    // Input register
    logic                            r_in_valid;
    logic                            r_first;
    logic [abhv_pkg::WORD_W-1:0]     r_word;
    logic [abhv_pkg::LEN_W-1:0]      r_len;

    logic                            step_ready;
    logic                            ev_valid;
    logic                            ev_ready;
    abhv_pkg::t_evt                  ev;
    logic [COUNT_WIDTH-1:0]          ev_product;
    abhv_pkg::t_status               status;

    assign i_in.ready = !r_in_valid || step_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_in_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_first <= i_in.first;
            r_word  <= i_in.word;
            r_len   <= i_in.payload_bytes;
        end
    end

    // Header walker
    abhv_step #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_step (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (r_in_valid),
        .o_ready         (step_ready),
        .i_first         (r_first),
        .i_word          (r_word),
        .i_payload_bytes (r_len),
        .o_ev_valid      (ev_valid),
        .i_ev_ready      (ev_ready),
        .o_ev            (ev),
        .o_ev_product    (ev_product)
    );

    // Verdict and result register
    abhv_verdict #(
        .VALUE_BYTES (VALUE_BYTES),
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_verdict (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (ev_valid),
        .o_ready   (ev_ready),
        .i_ev      (ev),
        .i_product (ev_product),
        .o_valid   (o_out.valid),
        .i_ready   (o_out.ready),
        .o_status  (status),
        .o_dims    (o_out.dimension_count),
        .o_values  (o_out.value_count),
        .o_offset  (o_out.data_offset)
    );

    assign o_out.status = status;

endmodule

`default_nettype wire

// File: test/tb.sv
// Self-checking testbench for the array blob header validator.
`timescale 1ns / 1ps

module tb;

    localparam int VB = abhv_pkg::DEF_VALUE_BYTES;
    localparam int CW = abhv_pkg::DEF_COUNT_WIDTH;
    localparam logic [63:0] CNT_MAX = {64{1'b1}} >> (64 - CW);
    localparam logic [63:0] VB64 = VB;
    localparam int RANDOM_WORDS = 1750;

    // One header word as offered on the input channel
    typedef struct {
        bit          first;
        logic [31:0] word;
        logic [31:0] len;
    } t_hdr_word;

    // One verdict as it should appear on the output channel
    typedef struct {
        abhv_pkg::t_status          status;
        logic [abhv_pkg::DIM_W-1:0] dims;
        logic [abhv_pkg::DIM_W-1:0] vals;
        logic [abhv_pkg::LEN_W-1:0] offs;
    } t_verdict;

    typedef enum {
        BLOB_OK, BLOB_LEN, BLOB_NEG, BLOB_OVF, BLOB_OVF_END,
        BLOB_BIG, BLOB_BAD_HDR, BLOB_RESTART, BLOB_NOISE
    } t_blob_kind;

    logic i_clk;
    logic i_rst_n;

    abhv_in_if  in_bus ();
    abhv_out_if out_bus ();

    array_blob_header_validator u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_bus),
        .o_out   (out_bus)
    );

    t_hdr_word pending_words[$];
    t_verdict  exp_verdicts[$];
    t_hdr_word drv_word;
    t_verdict  pred_v;
    t_verdict  want_v;
    int        err_cnt = 0;
    int        words_queued = 0;

    // Shadow of the header walker state
    bit          hp_busy;
    logic [31:0] hp_dims_total;
    logic [31:0] hp_dims_left;
    logic [31:0] hp_len;
    logic [63:0] hp_prod;

    bit          in_taken;
    int unsigned in_gap;
    int unsigned out_gap;
    bit          calm;
    int unsigned calm_left;

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Hard stop
    initial begin
        #2_000_000;
        $display("Simulation FAILED");
        $finish;
    end

    task automatic report_mismatch(input string what, input logic [63:0] exp_v,
                                   input logic [63:0] got_v);
        $display("MISMATCH %s: expected 0x%0h got 0x%0h at %0t", what, exp_v, got_v, $realtime);
        err_cnt++;
    endtask

    // Walks one header word through the shadow state; returns 1 when a verdict is due
    function automatic bit predict_verdict(input bit first, input logic [31:0] w,
                                           input logic [31:0] len, output t_verdict v);
        logic [63:0] hdr;
        logic [63:0] rest;
        v.status = abhv_pkg::ST_OK;
        v.dims   = '0;
        v.vals   = '0;
        v.offs   = '0;
        if (first) begin
            hp_busy = 1'b0;
            if (len < 32'd4) begin
                v.status = abhv_pkg::ST_SHORT;
                return 1'b1;
            end
            if (w[31] || w == 32'd0 || w > (len - 32'd4) / 32'd4) begin
                v.status = abhv_pkg::ST_DIMS;
                return 1'b1;
            end
            hp_busy       = 1'b1;
            hp_dims_total = w;
            hp_dims_left  = w;
            hp_len        = len;
            hp_prod       = 64'd1;
            return 1'b0;
        end
        // stray word
        if (!hp_busy)
            return 1'b0;
        if (w[31]) begin
            hp_busy  = 1'b0;
            v.status = abhv_pkg::ST_NEG;
            return 1'b1;
        end
        if (w == 32'd0) begin
            hp_prod = 64'd0;
        end else if (hp_prod != 64'd0) begin
            if ({32'd0, w} > CNT_MAX / hp_prod) begin
                hp_busy  = 1'b0;
                v.status = abhv_pkg::ST_OVF;
                return 1'b1;
            end
            hp_prod = hp_prod * {32'd0, w};
        end
        hp_dims_left = hp_dims_left - 32'd1;
        if (hp_dims_left != 32'd0)
            return 1'b0;
        hp_busy = 1'b0;
        if (hp_prod > CNT_MAX / VB64) begin
            v.status = abhv_pkg::ST_OVF;
            return 1'b1;
        end
        hdr  = 64'd4 + 64'd4 * {32'd0, hp_dims_total};
        rest = {32'd0, hp_len} - hdr;
        if (rest != hp_prod * VB64) begin
            v.status = abhv_pkg::ST_LEN;
            return 1'b1;
        end
        v.dims = hp_dims_total[abhv_pkg::DIM_W-1:0];
        v.vals = hp_prod[abhv_pkg::DIM_W-1:0];
        v.offs = hdr[abhv_pkg::LEN_W-1:0];
        return 1'b1;
    endfunction

    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (calm || r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(4, 30);
    endfunction

    task automatic put_word(input bit first, input logic [31:0] w, input logic [31:0] len);
        t_hdr_word h;
        h.first = first;
        h.word  = w;
        h.len   = len;
        pending_words.push_back(h);
        words_queued++;
    endtask

    // Size word; the length field is junk and must be ignored
    task automatic put_size(input logic [31:0] w);
        put_word(1'b0, w, $urandom);
    endtask

    // Queues one blob of the given flavor
    task automatic gen_blob(input t_blob_kind kind);
        int unsigned nd;
        int unsigned pos;
        logic [31:0] sz[8];
        logic [63:0] prod;
        logic [63:0] blen;
        logic [31:0] l;
        int          i;
        nd   = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 8) : $urandom_range(1, 4);
        prod = 64'd1;
        for (i = 0; i < nd; i++) begin
            sz[i] = ($urandom_range(0, 15) == 0) ? 32'd0 : $urandom_range(1, 6);
            prod  = prod * sz[i];
        end
        blen = 64'd4 + 64'd4 * nd + prod * VB64;
        case (kind)
            BLOB_OK, BLOB_LEN: begin
                if (kind == BLOB_LEN) begin
                    if (prod != 0 && $urandom_range(0, 1) == 1)
                        blen = blen - 64'd4 * $urandom_range(1, 2);
                    else
                        blen = blen + $urandom_range(1, 40);
                end
                put_word(1'b1, nd, blen[31:0]);
                for (i = 0; i < nd; i++)
                    put_size(sz[i]);
            end
            BLOB_NEG: begin
                pos = $urandom_range(0, nd - 1);
                sz[pos] = 32'h8000_0000 | $urandom;
                put_word(1'b1, nd, blen[31:0]);
                for (i = 0; i < nd; i++)
                    put_size(sz[i]);
            end
            BLOB_OVF: begin
                // third multiply runs past the count width
                nd = $urandom_range(3, 4);
                put_word(1'b1, nd, $urandom_range(32'h100, 32'hFFFF_FFFF));
                for (i = 0; i < nd; i++)
                    put_size($urandom_range(32'h4000_0000, 32'h7FFF_FFFF));
            end
            BLOB_OVF_END: begin
                // product fits but product times element bytes may not
                put_word(1'b1, 2, $urandom_range(32'h10, 32'hFFFF_FFFF));
                if ($urandom_range(0, 2) == 0) begin
                    put_size(32'h4000_0000);
                    put_size($urandom_range(32'h7FFF_FFF0, 32'h7FFF_FFFF));
                end else begin
                    put_size($urandom_range(32'h6000_0000, 32'h7FFF_FFFF));
                    put_size($urandom_range(32'h6000_0000, 32'h7FFF_FFFF));
                end
            end
            BLOB_BIG: begin
                sz[0] = $urandom_range(1, 32'h1FFF_FFFE);
                blen  = 64'd12 + {32'd0, sz[0]} * VB64;
                put_word(1'b1, 1, blen[31:0]);
                put_size(sz[0]);
            end
            BLOB_BAD_HDR: begin
                case ($urandom_range(0, 3))
                    0: put_word(1'b1, $urandom, $urandom_range(0, 3));
                    1: begin
                        l = $urandom_range(4, 32'hFFFF_FFFF);
                        put_word(1'b1, (l - 32'd4) / 32'd4 + $urandom_range(1, 5), l);
                    end
                    2: put_word(1'b1, ($urandom_range(0, 1) == 1) ? 32'd0
                                      : (32'h8000_0000 | $urandom), $urandom);
                    default: begin
                        // count exactly at the limit the length allows
                        l = 32'd4 + 32'd4 * nd + $urandom_range(0, 3);
                        put_word(1'b1, nd, l);
                        for (i = 0; i < nd; i++)
                            put_size(sz[i]);
                    end
                endcase
            end
            BLOB_RESTART: begin
                // cut a blob short, then a complete one abandons it
                put_word(1'b1, nd + 1, blen[31:0] + 32'd4);
                pos = $urandom_range(0, nd);
                for (i = 0; i < pos; i++)
                    put_size(sz[i % 8]);
                gen_blob(BLOB_OK);
            end
            default: begin
                for (i = 0; i < $urandom_range(1, 3); i++)
                    put_word($urandom_range(0, 3) == 0, $urandom, $urandom);
            end
        endcase
    endtask

    // Main sequence: reset, stimulus, drain, verdict
    initial begin
        int       wait_cnt;
        int       r;
        int       directed_cnt;
        in_bus.valid         = 1'b0;
        in_bus.first         = 1'b0;
        in_bus.word          = '0;
        in_bus.payload_bytes = '0;
        out_bus.ready        = 1'b0;
        i_rst_n              = 1'b0;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed corners
        put_size(32'h7FFF_FFFF);                      // stray word while idle
        put_word(1'b1, 32'd1, 32'd0);                 // too short
        put_word(1'b1, 32'hFFFF_FFFF, 32'd3);         // too short, negative count
        put_word(1'b1, 32'd1, 32'd4);                 // no room for any size
        put_word(1'b1, 32'd0, 32'hFFFF_FFFF);         // zero count
        put_word(1'b1, 32'h8000_0000, 32'hFFFF_FFFF); // most negative count
        put_word(1'b1, 32'h7FFF_FFFF, 32'hFFFF_FFFF); // count beyond room
        put_word(1'b1, 32'd1, 32'd16);                // good single dimension
        put_size(32'd1);
        put_word(1'b1, 32'd1, 32'd16);                // negative size
        put_size(32'h8000_0000);
        put_word(1'b1, 32'd2, 32'd12);                // zero size sticks
        put_size(32'd0);
        put_size(32'd5);
        put_word(1'b1, 32'd3, 32'hFFFF_FFFF);         // product overflow
        put_size(32'h7FFF_FFFF);
        put_size(32'h7FFF_FFFF);
        put_size(32'h7FFF_FFFF);
        put_word(1'b1, 32'd1, 32'd100);               // length mismatch
        put_size(32'd7);
        put_word(1'b1, 32'd3, 32'd100);               // abandoned by restart
        put_size(32'd2);
        put_word(1'b1, 32'd1, 32'd16);
        put_size(32'd1);
        put_size(32'd5);                              // stray after verdict
        directed_cnt = words_queued;

        // random blobs, mostly well formed
        while (words_queued < directed_cnt + RANDOM_WORDS) begin
            r = $urandom_range(0, 99);
            if (r < 50)      gen_blob(BLOB_OK);
            else if (r < 62) gen_blob(BLOB_LEN);
            else if (r < 68) gen_blob(BLOB_NEG);
            else if (r < 73) gen_blob(BLOB_OVF);
            else if (r < 78) gen_blob(BLOB_OVF_END);
            else if (r < 83) gen_blob(BLOB_BIG);
            else if (r < 89) gen_blob(BLOB_BAD_HDR);
            else if (r < 95) gen_blob(BLOB_RESTART);
            else             gen_blob(BLOB_NOISE);
        end

        // wait for the last transaction to go in
        while (pending_words.size() != 0 || in_bus.valid)
            @(negedge i_clk);
        wait_cnt = 0;
        while (exp_verdicts.size() != 0 && wait_cnt < 5000) begin
            @(negedge i_clk);
            wait_cnt++;
        end
        repeat (10) @(negedge i_clk);
        if (exp_verdicts.size() != 0)
            report_mismatch("verdicts never delivered", 0, exp_verdicts.size());
        if (err_cnt == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    // Stretches where neither side idles
    always @(negedge i_clk) begin
        if (calm_left != 0) begin
            calm_left <= calm_left - 1;
        end else begin
            calm      <= ($urandom_range(0, 3) == 0);
            calm_left <= $urandom_range(20, 200);
        end
    end

    // Input driver
    always @(negedge i_clk) begin
        if (in_bus.valid && !in_taken) begin
            // hold until taken
        end else if (in_gap != 0) begin
            in_bus.valid <= 1'b0;
            in_gap       <= in_gap - 1;
        end else if (pending_words.size() != 0) begin
            drv_word             = pending_words.pop_front();
            in_bus.first         <= drv_word.first;
            in_bus.word          <= drv_word.word;
            in_bus.payload_bytes <= drv_word.len;
            in_bus.valid         <= 1'b1;
            in_gap               <= pick_gap();
        end else begin
            in_bus.valid <= 1'b0;
        end
    end

    // Output ready driver
    always @(negedge i_clk) begin
        if (out_gap != 0) begin
            out_bus.ready <= 1'b0;
            out_gap       <= out_gap - 1;
        end else begin
            out_bus.ready <= 1'b1;
            out_gap       <= ($urandom_range(0, 3) == 0) ? pick_gap() : 0;
        end
    end

    // Input monitor: each accepted transaction feeds the predictor
    always @(posedge i_clk) begin
        in_taken <= i_rst_n && in_bus.valid && in_bus.ready;
        if (!i_rst_n) begin
            hp_busy       = 1'b0;
            hp_dims_total = '0;
            hp_dims_left  = '0;
            hp_len        = '0;
            hp_prod       = 64'd1;
        end else if (in_bus.valid && in_bus.ready) begin
            if (predict_verdict(in_bus.first, in_bus.word, in_bus.payload_bytes, pred_v))
                exp_verdicts.push_back(pred_v);
        end
    end

    // Output monitor: compare each verdict with the oldest prediction
    always @(posedge i_clk) begin
        if (i_rst_n && out_bus.valid && out_bus.ready) begin
            if (exp_verdicts.size() == 0) begin
                report_mismatch("unexpected verdict, status", 0, out_bus.status);
            end else begin
                want_v = exp_verdicts.pop_front();
                if (out_bus.status !== want_v.status)
                    report_mismatch("status", want_v.status, out_bus.status);
                if (out_bus.dimension_count !== want_v.dims)
                    report_mismatch("dimension_count", want_v.dims, out_bus.dimension_count);
                if (out_bus.value_count !== want_v.vals)
                    report_mismatch("value_count", want_v.vals, out_bus.value_count);
                if (out_bus.data_offset !== want_v.offs)
                    report_mismatch("data_offset", want_v.offs, out_bus.data_offset);
            end
        end
    end

endmodule
